// File: hw/rtl/open_address_hash_set_defines.svh
// assertion macros for the checker file of the hash set
// clocked on clk_i, reset by rst_ni of the module that uses them
`ifndef OPEN_ADDRESS_HASH_SET_DEFINES_SVH
`define OPEN_ADDRESS_HASH_SET_DEFINES_SVH

// checked outside reset only
`define OHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define OHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/ohs_pkg.sv
// types, constants and key compare functions of the hash set
// no dependencies
package ohs_pkg;

  localparam int unsigned LOG2_BUCKETS_DEF = 10;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned ENTRY_W = KEY_W + 1;
  localparam int unsigned COUNT_W = 10;

  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] EXP_ALL = 64'h7FF0_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH0,
    ST_HASH1,
    ST_HASH2,
    ST_PROBE,
    ST_CMP
  } state_e;

  function automatic logic key_is_nan(input logic [63:0] k);
    return (k & ABS_MASK) > EXP_ALL;
  endfunction

  function automatic logic key_is_zero(input logic [63:0] k);
    return (k & ABS_MASK) == 64'd0;
  endfunction

  // double compare: signed zeros equal, nan matches nothing
  function automatic logic keys_equal(input logic [63:0] a, input logic [63:0] b);
    logic eq;
    eq = 1'b0;
    if (!key_is_nan(a) && !key_is_nan(b)) begin
      eq = (key_is_zero(a) && key_is_zero(b)) || (a == b);
    end
    return eq;
  endfunction

endpackage

// File: hw/rtl/open_address_hash_set.sv
// open-addressing hash set of double keys, top level
// depends on ohs_pkg and ohs_ram
//
// input channel: in_valid_i / in_stall_o with mode_i (0 query, 1 add) and key_i.
// output channel: out_valid_o / out_stall_i with found_o, added_o, full_res_o
// and count_o, one result beat for each input beat, in order.
// a beat moves on a rising edge where valid is high and stall is low.
// the key is hashed by a shared 32x32 multiplier in states HASH0 to HASH2, then the
// table ram is probed one bucket per cycle (each read issued ahead of its compare).
// in_stall_o is high from an accepted input beat until its result is written to
// the output register, so a new input beat is not taken before the last finishes.
// how long a beat takes is set by the hash states and the probe loop.
// the result sits in an output register: the next item is accepted while it
// waits; a finished item waits in its last probe while the receiver stalls.
// at reset the table ram is cleared, one bucket per cycle, and in_stall_o
// is high until every bucket has been cleared.
// adds are refused with full_res_o once 4*(count+1) > 3*2^LOG2_BUCKETS.
module open_address_hash_set
  import ohs_pkg::*;
#(
  parameter int unsigned LOG2_BUCKETS = LOG2_BUCKETS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [KEY_W-1:0]   key_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic               added_o,
  output logic               full_res_o,
  output logic [COUNT_W-1:0] count_o
);

  localparam int unsigned NumBuckets = 1 << LOG2_BUCKETS;
  localparam int unsigned CntW = LOG2_BUCKETS + 1;
  localparam int unsigned LimW = CntW + 3;
  localparam logic [LimW-1:0] Limit = LimW'(3) << LOG2_BUCKETS;

  state_e state_q, state_d;

  logic [LOG2_BUCKETS-1:0] idx_q, idx_d;
  logic [LOG2_BUCKETS-1:0] step_q, step_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [31:0]             hi_q, hi_d;
  logic [KEY_W-1:0]        key_q;
  logic                    mode_q;

  logic                    out_valid_q, out_valid_d;
  logic                    found_q, added_q, full_q;
  logic                    finish;

  logic [KEY_W-1:0]        hkey;
  logic [31:0]             mul_a, mul_b;
  logic [63:0]             mul_p;
  logic [31:0]             hsum;

  logic                    ram_we, ram_re;
  logic [LOG2_BUCKETS-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;

  logic                    ent_used, match, done, out_free, limit_hit, do_add;
  logic [LimW-1:0]         need;

  // signed zeros hash alike
  assign hkey = key_is_zero(key_q) ? '0 : key_q;

  // top bits of the 64-bit product need kl*ml high half plus the low halves
  // of the two cross products
  always_comb begin
    case (state_q)
      ST_HASH0: begin
        mul_a = hkey[31:0];
        mul_b = HASH_MULT[31:0];
      end
      ST_HASH1: begin
        mul_a = hkey[63:32];
        mul_b = HASH_MULT[31:0];
      end
      default: begin
        mul_a = hkey[31:0];
        mul_b = HASH_MULT[63:32];
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign hsum  = hi_q + mul_p[31:0];

  assign ent_used  = ram_rdata[ENTRY_W-1];
  assign match     = ent_used && keys_equal(ram_rdata[KEY_W-1:0], key_q);
  assign done      = !ent_used || match;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign need      = LimW'({cnt_q, 2'b00}) + LimW'(4);
  assign limit_hit = need > Limit;
  assign do_add    = mode_q && !match && !limit_hit;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    hi_d      = hi_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {1'b1, key_q};
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    finish    = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_d     = idx_q + LOG2_BUCKETS'(1);
        if (idx_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_HASH0;
        end
      end
      ST_HASH0: begin
        hi_d    = mul_p[63:32];
        state_d = ST_HASH1;
      end
      ST_HASH1: begin
        hi_d    = hsum;
        state_d = ST_HASH2;
      end
      ST_HASH2: begin
        idx_d   = hsum[31 -: LOG2_BUCKETS];
        step_d  = LOG2_BUCKETS'(1);
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        ram_re  = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!done) begin
          // next bucket read goes out while this one is compared
          idx_d     = idx_q + step_q;
          step_d    = step_q + LOG2_BUCKETS'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_q + step_q;
        end else if (out_free) begin
          finish  = 1'b1;
          ram_we  = do_add;
          if (do_add) begin
            cnt_d = cnt_q + CntW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = finish ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      key_q  <= key_i;
      mode_q <= mode_i;
    end
    if (finish) begin
      found_q <= match;
      added_q <= do_add;
      full_q  <= mode_q && !match && limit_hit;
    end
  end

  ohs_ram #(
    .Width (ENTRY_W),
    .Depth (NumBuckets)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign added_o     = added_q;
  assign full_res_o  = full_q;
  assign count_o     = COUNT_W'(cnt_q);

endmodule

// File: hw/rtl/ohs_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ohs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ohs_checker.sv
// port-level checks of the hash set, bound to the top level
// depends on ohs_pkg and open_address_hash_set_defines.svh
`include "open_address_hash_set_defines.svh"

module ohs_checker
  import ohs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               found_o,
  input logic               added_o,
  input logic               full_res_o,
  input logic [COUNT_W-1:0] count_o
);

  logic               out_beat;
  logic               in_beat;
  logic               stalled;
  logic               flags_ok;
  logic [COUNT_W-1:0] cnt_track_q;
  logic [COUNT_W-1:0] cnt_want;

  assign out_beat = out_valid_o && !out_stall_i;
  assign in_beat  = in_valid_i && !in_stall_o;
  assign stalled  = out_valid_o && out_stall_i;
  assign flags_ok = !(found_o && added_o) && !(full_res_o && (found_o || added_o));
  assign cnt_want = cnt_track_q + COUNT_W'(added_o);

  // count seen on the previous result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_track_q <= '0;
    end else if (out_beat) begin
      cnt_track_q <= count_o;
    end
  end

  `OHS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && in_stall_o, "busy in reset")
  `OHS_ASSERT(a_flags_exclusive, out_valid_o |-> flags_ok, "result flags clash")
  `OHS_ASSERT(a_count_step, out_beat |-> count_o == cnt_want, "count off")
  `OHS_ASSERT(a_out_hold, stalled |=> out_valid_o && $stable(count_o) && $stable(found_o), "moved")
  `OHS_ASSERT(a_no_overlap, in_beat |=> in_stall_o, "second beat taken while busy")

endmodule

bind open_address_hash_set ohs_checker u_ohs_checker (.*);
